// ----- design/scc_pkg.sv -----
// ----------------------------------------------------------------------------
// scc_pkg
// Shared constants, codes and elaboration-time log tables for the sector
// content classifier.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int BLOCK_BYTES_DEF   = 512;
  localparam int MAX_PERIOD_DEF    = 19;
  localparam int ENTROPY_FRAC_DEF  = 16;

  localparam int HDR_LEN           = 11;
  localparam int JPEG_MIN_DISTINCT = 220;
  localparam int PAIR_MAX          = 1023;
  localparam int PAIR_MIN          = 2;

  localparam int THRESH_W          = 20;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 20'd458752;

  // register addresses on the APB port
  localparam logic [1:0] REG_THRESH = 2'd0;

  localparam int PLEN_W            = 5;
  localparam int BLK_W             = 16;
  // record head: block number, class, period, header flag
  localparam int REC_HEAD_W        = BLK_W + 2 + PLEN_W + 1;

  localparam int DELTA_W           = 40;   // one step of c*L(c), below 2^37
  localparam int SUM_W             = 50;   // running sum of c*L(c)
  localparam int FIFO_DEPTH        = 4;

  localparam logic [7:0] MARK_FF   = 8'hFF;
  localparam logic [7:0] MARK_00   = 8'h00;

  typedef enum logic [1:0] {
    KIND_CONST = 2'd0,
    KIND_JPEG  = 2'd1,
    KIND_COMP  = 2'd2,
    KIND_HDR   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CLS_NONE  = 2'd0,
    CLS_CONST = 2'd1,
    CLS_JPEG  = 2'd2,
    CLS_COMP  = 2'd3
  } cls_t;

  // volume header signature, byte by byte
  function automatic logic [7:0] hdr_sig(input logic [3:0] i);
    logic [7:0] s;
    case (i)
      4'd0:    s = 8'hEB;
      4'd1:    s = 8'h52;
      4'd2:    s = 8'h90;
      4'd3:    s = 8'h2D;
      4'd4:    s = 8'h46;
      4'd5:    s = 8'h56;
      4'd6:    s = 8'h45;
      4'd7:    s = 8'h2D;
      4'd8:    s = 8'h46;
      4'd9:    s = 8'h53;
      4'd10:   s = 8'h2D;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // log2(c), 32 fraction bits, truncated; elaboration only
  function automatic logic [63:0] log2_fixed(input int unsigned c);
    int unsigned k;
    int          i;
    logic [127:0] y;
    logic [31:0]  fr;
    k  = 0;
    fr = '0;
    while (k < 31 && (c >> (k + 1)) != 0) k++;
    y = 128'(c) << (31 - k);
    for (i = 0; i < 32; i++) begin
      y  = (y * y) >> 31;
      fr = {fr[30:0], 1'b0};
      if (y >= 128'h1_0000_0000) begin
        y     = y >> 1;
        fr[0] = 1'b1;
      end
    end
    return {k[31:0], fr};
  endfunction

  // c*L(c) - (c-1)*L(c-1)
  function automatic logic [DELTA_W-1:0] log_delta(input int unsigned c);
    logic [127:0] t1;
    logic [127:0] t0;
    t1 = '0;
    t0 = '0;
    if (c > 1) begin
      t1 = 128'(c) * 128'(log2_fixed(c));
      t0 = 128'(c - 1) * 128'(log2_fixed(c - 1));
    end
    return DELTA_W'(t1 - t0);
  endfunction

  // N * L(N)
  function automatic logic [SUM_W-1:0] block_nln(input int unsigned n);
    logic [127:0] t;
    t = 128'(n) * 128'(log2_fixed(n));
    return SUM_W'(t);
  endfunction

endpackage

// ----- design/scc_fifo.sv -----
// ----------------------------------------------------------------------------
// scc_fifo
// Short record queue between the classifying front and the result back end.
// ----------------------------------------------------------------------------
module scc_fifo #(
  parameter int WIDTH = 176,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       nonempty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wp;
  logic [AW-1:0]    rp;

  assign rdata    = mem[rp];
  assign nonempty = (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (!push && pop) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
  end

endmodule

// ----- design/scc_front.sv -----
// ----------------------------------------------------------------------------
// scc_front
// Per-byte statistics (histogram, periods, pairs, header, entropy sum) and
// block classification into a queue record for each classified or header block.
// ----------------------------------------------------------------------------
module scc_front #(
  parameter int BLOCK_BYTES       = 512,
  parameter int MAX_PERIOD        = 19,
  parameter int ENTROPY_FRAC_BITS = 16
) (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           acc,
  input  logic [7:0]                                     data_byte,
  input  logic [scc_pkg::THRESH_W-1:0]                   threshold,
  output logic                                           push,
  output logic [scc_pkg::REC_HEAD_W+8*MAX_PERIOD-1:0]    rec
);

  import scc_pkg::*;

  localparam int PW    = $clog2(BLOCK_BYTES);
  localparam int CW    = $clog2(BLOCK_BYTES + 1);
  localparam int PIW   = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
  localparam int PRE_W = 8 * MAX_PERIOD;
  localparam int K     = 32 - ENTROPY_FRAC_BITS;
  localparam int SHL   = (ENTROPY_FRAC_BITS >= 16) ? ENTROPY_FRAC_BITS - 16 : 0;
  localparam int SHR   = (ENTROPY_FRAC_BITS >= 16) ? 0 : 16 - ENTROPY_FRAC_BITS;
  localparam int RW    = 40;
  localparam logic [SUM_W-1:0] N_LN = block_nln(BLOCK_BYTES);

  // c*L(c) step table, read through a register
  logic [DELTA_W-1:0] rom [BLOCK_BYTES+1];
  for (genvar g = 0; g <= BLOCK_BYTES; g++) begin : g_rom
    localparam logic [DELTA_W-1:0] DV = log_delta(g);
    assign rom[g] = DV;
  end

  // ---- stage 1: histogram and byte statistics
  logic [CW-1:0]  hist [256];
  logic [255:0]   hv;
  logic           v1;
  logic [7:0]     b1;
  logic [CW-1:0]  rd_q;
  logic           fwd;
  logic [CW-1:0]  fwd_c;
  logic [PW-1:0]  pos;
  logic [7:0]     prev;
  logic [9:0]     pairs;
  logic [8:0]     distinct;
  logic [MAX_PERIOD-1:0] flags;
  logic [PIW-1:0] phase [MAX_PERIOD];
  logic [7:0]     prefix [MAX_PERIOD];
  logic           hdr;
  logic [BLK_W-1:0] blk;

  logic [CW-1:0]  c_old;
  logic [CW-1:0]  c_new;
  logic           last1;
  logic [9:0]     pairs_next;
  logic [8:0]     distinct_next;
  logic           hdr_next;
  logic [MAX_PERIOD-1:0] flags_next;
  logic [PIW-1:0] phase_next [MAX_PERIOD];

  assign c_old = fwd ? fwd_c : (hv[b1] ? rd_q : '0);
  assign c_new = c_old + 1'b1;
  assign last1 = (pos == PW'(BLOCK_BYTES - 1));

  always_comb begin
    pairs_next    = (pos != '0 && prev == MARK_FF && b1 == MARK_00 &&
                     pairs != 10'(PAIR_MAX)) ? pairs + 1'b1 : pairs;
    distinct_next = (c_old == '0) ? distinct + 1'b1 : distinct;
    hdr_next      = (pos < PW'(HDR_LEN) && b1 != hdr_sig(pos[3:0])) ? 1'b0 : hdr;
    flags_next    = flags;
    for (int p = 1; p <= MAX_PERIOD; p++) begin
      phase_next[p-1] = phase[p-1];
      if (pos >= PW'(p)) begin
        if (prefix[phase[p-1]] != b1) flags_next[p-1] = 1'b0;
        phase_next[p-1] = (phase[p-1] == PIW'(p - 1)) ? '0 : phase[p-1] + 1'b1;
      end
    end
  end

  // ---- stage 2: entropy sum and block record
  logic               v2;
  logic               last2;
  logic [DELTA_W-1:0] dq;
  logic [SUM_W-1:0]   sum;
  logic [MAX_PERIOD-1:0] sn_flags;
  logic               sn_jpeg;
  logic               sn_hdr;
  logic [BLK_W-1:0]   sn_blk;
  logic [PRE_W-1:0]   sn_pre;

  // threshold turned into a bound on the sum of c*L(c)
  logic [RW-1:0]      m_w;
  logic [RW-1:0]      r_q;
  logic [SUM_W-1:0]   rn_q;
  logic [SUM_W:0]     lim_q;

  assign m_w = (RW'(threshold) << SHL) >> SHR;

  always_ff @(posedge clk) begin
    r_q   <= ((m_w + 1'b1) << K) - (RW'(1) << (K - 1));
    rn_q  <= SUM_W'(r_q) * SUM_W'(BLOCK_BYTES);
    lim_q <= {1'b0, N_LN} - {1'b0, rn_q};
  end

  logic [SUM_W-1:0]  sig_fin;
  logic              comp;
  logic [PLEN_W-1:0] plen_f;
  cls_t              cls;

  always_comb begin
    sig_fin = sum + SUM_W'(dq);
    comp    = !lim_q[SUM_W] && (sig_fin <= lim_q[SUM_W-1:0]);
    plen_f  = '0;
    for (int p = MAX_PERIOD; p >= 1; p--) begin
      if (sn_flags[p-1]) plen_f = PLEN_W'(p);
    end
    if (|sn_flags)    cls = CLS_CONST;
    else if (sn_jpeg) cls = CLS_JPEG;
    else if (comp)    cls = CLS_COMP;
    else              cls = CLS_NONE;
  end

  assign push = v2 && last2 && (cls != CLS_NONE || sn_hdr);
  assign rec  = {sn_blk, cls, plen_f, sn_hdr, sn_pre};

  // histogram memory, read on every cycle, written from stage 1
  always_ff @(posedge clk) begin
    rd_q <= hist[data_byte];
    if (v1) hist[b1] <= c_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      fwd      <= 1'b0;
      hv       <= '0;
      pos      <= '0;
      prev     <= '0;
      pairs    <= '0;
      distinct <= '0;
      flags    <= '1;
      hdr      <= 1'b1;
      blk      <= '0;
      v2       <= 1'b0;
      last2    <= 1'b0;
      sum      <= '0;
      for (int p = 0; p < MAX_PERIOD; p++) phase[p] <= '0;
    end else begin
      v1    <= acc;
      fwd   <= acc && v1 && !last1 && (b1 == data_byte);
      v2    <= v1;
      last2 <= v1 && last1;
      if (v1) begin
        if (last1) begin
          hv       <= '0;
          pos      <= '0;
          prev     <= '0;
          pairs    <= '0;
          distinct <= '0;
          flags    <= '1;
          hdr      <= 1'b1;
          blk      <= blk + 1'b1;
          for (int p = 0; p < MAX_PERIOD; p++) phase[p] <= '0;
        end else begin
          hv[b1]   <= 1'b1;
          pos      <= pos + 1'b1;
          prev     <= b1;
          pairs    <= pairs_next;
          distinct <= distinct_next;
          flags    <= flags_next;
          hdr      <= hdr_next;
          for (int p = 0; p < MAX_PERIOD; p++) phase[p] <= phase_next[p];
        end
      end
      if (v2) sum <= last2 ? '0 : sig_fin;
    end
  end

  always_ff @(posedge clk) begin
    b1    <= data_byte;
    fwd_c <= c_new;
    dq    <= rom[c_new];
    if (v1 && pos < PW'(MAX_PERIOD)) prefix[pos[PIW-1:0]] <= b1;
    if (v1 && last1) begin
      sn_flags <= flags_next;
      sn_jpeg  <= (pairs_next > 10'(PAIR_MIN)) &&
                  (distinct_next >= 9'(JPEG_MIN_DISTINCT));
      sn_hdr   <= hdr_next;
      sn_blk   <= blk;
      for (int i = 0; i < MAX_PERIOD; i++) sn_pre[8*i +: 8] <= prefix[i];
    end
  end

endmodule

// ----- design/scc_back.sv -----
// ----------------------------------------------------------------------------
// scc_back
// Expands one block record into its result beats behind an output register.
// ----------------------------------------------------------------------------
module scc_back #(
  parameter int MAX_PERIOD = 19
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        rec_valid,
  input  logic [scc_pkg::REC_HEAD_W+8*MAX_PERIOD-1:0] rec,
  output logic                                        pop,
  output logic [scc_pkg::BLK_W-1:0]                   block_number,
  output logic [1:0]                                  kind,
  output logic [scc_pkg::PLEN_W-1:0]                  pattern_len,
  output logic [7:0]                                  pattern_byte,
  output logic                                        last,
  output logic                                        result_valid,
  input  logic                                        result_stall
);

  import scc_pkg::*;

  localparam int PRE_W = 8 * MAX_PERIOD;
  localparam int REC_W = REC_HEAD_W + PRE_W;

  logic              busy;
  logic [REC_W-1:0]  ent;
  logic [PLEN_W-1:0] idx;

  cls_t              e_cls;
  logic [PLEN_W-1:0] e_plen;
  logic              e_hdr;
  logic [BLK_W-1:0]  e_blk;
  logic [PLEN_W-1:0] n_cls;
  logic [PLEN_W-1:0] n_tot;
  logic              item_last;
  logic              take;
  logic [7:0]        pbyte;

  assign e_hdr  = ent[PRE_W];
  assign e_plen = ent[PRE_W+1 +: PLEN_W];
  assign e_cls  = cls_t'(ent[PRE_W+1+PLEN_W +: 2]);
  assign e_blk  = ent[PRE_W+3+PLEN_W +: BLK_W];

  always_comb begin
    case (e_cls)
      CLS_CONST: n_cls = e_plen;
      CLS_JPEG:  n_cls = PLEN_W'(1);
      CLS_COMP:  n_cls = PLEN_W'(1);
      default:   n_cls = '0;
    endcase
    n_tot = n_cls + PLEN_W'(e_hdr);
    pbyte = '0;
    for (int i = 0; i < MAX_PERIOD; i++) begin
      if (idx == PLEN_W'(i)) pbyte = ent[8*i +: 8];
    end
  end

  assign item_last = (idx == n_tot - 1'b1);
  assign take      = !result_valid || !result_stall;
  assign pop       = !busy && rec_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      idx          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (take) result_valid <= busy;
      if (busy && take) begin
        idx <= idx + 1'b1;
        if (item_last) busy <= 1'b0;
      end else if (pop) begin
        busy <= 1'b1;
        idx  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) ent <= rec;
    if (busy && take) begin
      block_number <= e_blk;
      last         <= item_last;
      if (idx < n_cls) begin
        case (e_cls)
          CLS_CONST: begin
            kind         <= KIND_CONST;
            pattern_len  <= e_plen;
            pattern_byte <= pbyte;
          end
          CLS_JPEG: begin
            kind         <= KIND_JPEG;
            pattern_len  <= '0;
            pattern_byte <= '0;
          end
          default: begin
            kind         <= KIND_COMP;
            pattern_len  <= '0;
            pattern_byte <= '0;
          end
        endcase
      end else begin
        kind         <= KIND_HDR;
        pattern_len  <= '0;
        pattern_byte <= '0;
      end
    end
  end

endmodule

// ----- design/sector_content_classifier.sv -----
// ----------------------------------------------------------------------------
// sector_content_classifier
// Block classifier over a byte stream: constant pattern, jpeg, compressed,
// plus a volume header tag.
// ----------------------------------------------------------------------------
//  channel   | signals                                 | beat
//  ----------+-----------------------------------------+---------------------
//  bytes in  | byte_valid / byte_stall, data_byte      | one byte of a block
//  results   | result_valid / result_stall, fields     | one result item
//  config    | APB: psel penable pwrite paddr pwdata   | entropy_threshold @0
//
//  One byte per cycle is taken while byte_stall is low; stats and the entropy
//  sum are updated in a two-stage pipeline (histogram RAM with forwarding for
//  repeated bins). Results leave at one beat per cycle while result_stall is
//  low, with a gap between blocks set by the back end's record queue pop.
//  byte_stall rises only while the four-entry record queue is nearly full.
//  Reset is synchronous; histogram valid bits clear at once, no sweep.
//  A new threshold passes r_q, rn_q and lim_q before it reaches the compare.
// ----------------------------------------------------------------------------
module sector_content_classifier #(
  parameter int BLOCK_BYTES       = scc_pkg::BLOCK_BYTES_DEF,
  parameter int MAX_PERIOD        = scc_pkg::MAX_PERIOD_DEF,
  parameter int ENTROPY_FRAC_BITS = scc_pkg::ENTROPY_FRAC_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // config
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [1:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  // bytes in
  input  logic                      byte_valid,
  output logic                      byte_stall,
  input  logic [7:0]                data_byte,
  // results out
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic [15:0]               block_number,
  output logic [1:0]                kind,
  output logic [4:0]                pattern_len,
  output logic [7:0]                pattern_byte,
  output logic                      last
);

  import scc_pkg::*;

  localparam int REC_W = REC_HEAD_W + 8 * MAX_PERIOD;
  localparam int CNTW  = $clog2(FIFO_DEPTH + 1);

  logic [THRESH_W-1:0] threshold;
  logic                acc;
  logic                push;
  logic                pop;
  logic [REC_W-1:0]    rec_in;
  logic [REC_W-1:0]    rec_out;
  logic                rec_valid;
  logic [CNTW-1:0]     count;

  // config register
  assign pready = 1'b1;
  assign prdata = (paddr == REG_THRESH) ? {{(32-THRESH_W){1'b0}}, threshold} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_RESET;
    end else if (psel && penable && pwrite && paddr == REG_THRESH) begin
      threshold <= pwdata[THRESH_W-1:0];
    end
  end

  // at most one block end is in flight in the front pipeline
  assign byte_stall = (count >= CNTW'(FIFO_DEPTH - 1));
  assign acc        = byte_valid && !byte_stall;

  scc_front #(
    .BLOCK_BYTES      (BLOCK_BYTES),
    .MAX_PERIOD       (MAX_PERIOD),
    .ENTROPY_FRAC_BITS(ENTROPY_FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .acc      (acc),
    .data_byte(data_byte),
    .threshold(threshold),
    .push     (push),
    .rec      (rec_in)
  );

  scc_fifo #(
    .WIDTH(REC_W),
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wdata   (rec_in),
    .pop     (pop),
    .rdata   (rec_out),
    .nonempty(rec_valid),
    .count   (count)
  );

  scc_back #(
    .MAX_PERIOD(MAX_PERIOD)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .rec_valid   (rec_valid),
    .rec         (rec_out),
    .pop         (pop),
    .block_number(block_number),
    .kind        (kind),
    .pattern_len (pattern_len),
    .pattern_byte(pattern_byte),
    .last        (last),
    .result_valid(result_valid),
    .result_stall(result_stall)
  );

endmodule
